// ===== rtl/lgr_pkg.sv =====
// Shared types and helpers for the Game of Life row engine.
package lgr_pkg;

	// Columns carried by one row beat
	localparam int unsigned ROW_BITS = 32;

	// Depth of the result queue and the highest fill level at which input is still accepted
	localparam int unsigned OUTQ_DEPTH = 4;
	localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned OUTQ_CNT_W = OUTQ_PTR_W + 1;
	localparam logic [OUTQ_CNT_W-1:0] OUTQ_ACCEPT_MAX = OUTQ_CNT_W'(OUTQ_DEPTH - 2);

	// Number of result beats one input row pushes
	localparam logic [1:0] PUSH_NONE = 2'd0;
	localparam logic [1:0] PUSH_ONE  = 2'd1;
	localparam logic [1:0] PUSH_TWO  = 2'd2;

	typedef struct packed {
		logic [ROW_BITS-1:0] row_cells;
		logic                last_row;
	} in_beat_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] next_row;
		logic                last_out;
	} out_beat_t;

	// 3x3 neighborhood of one cell; bit 0 is the left column, bit 2 the right
	typedef struct packed {
		logic [2:0] above;
		logic [2:0] mid;
		logic [2:0] below;
	} nbhd_t;

	// Results handed from the row logic to the output queue
	typedef struct packed {
		logic [1:0] cnt;
		out_beat_t  beat0;
		out_beat_t  beat1;
	} push_t;

	// Mask of the columns that exist in a grid of the given width
	function automatic logic [ROW_BITS-1:0] lane_mask(input int unsigned lanes);
		logic [ROW_BITS-1:0] m;
		for (int unsigned i = 0; i < ROW_BITS; i++) begin
			m[i] = (i < lanes);
		end
		return m;
	endfunction

endpackage

// ===== rtl/lgr_cell.sv =====
// One lane: B3/S23 rule for a single cell from its 3x3 neighborhood.
module lgr_cell (
	input  lgr_pkg::nbhd_t nbhd,
	output logic           alive
);

	logic [3:0] n;

	// Live neighbor count, center excluded
	assign n = {3'b0, nbhd.above[0]} + {3'b0, nbhd.above[1]} + {3'b0, nbhd.above[2]}
		+ {3'b0, nbhd.mid[0]} + {3'b0, nbhd.mid[2]}
		+ {3'b0, nbhd.below[0]} + {3'b0, nbhd.below[1]} + {3'b0, nbhd.below[2]};

	assign alive = (n == 4'd3) || ((n == 4'd2) && nbhd.mid[1]);

endmodule

// ===== rtl/lgr_row.sv =====
// Row of cell lanes computing the next generation of one row; merges lane bits.
module lgr_row #(
	parameter int unsigned LANES = 32
) (
	input  logic [lgr_pkg::ROW_BITS-1:0] above,
	input  logic [lgr_pkg::ROW_BITS-1:0] mid,
	input  logic [lgr_pkg::ROW_BITS-1:0] below,
	output logic [lgr_pkg::ROW_BITS-1:0] res
);

	for (genvar c = 0; c < lgr_pkg::ROW_BITS; c++) begin : g_col
		if (c < LANES) begin : g_lane
			lgr_pkg::nbhd_t nb;
			logic           bit_alive;

			// Columns left of 0 and right of the last lane read as dead
			if (c > 0) begin : g_left
				assign nb.above[0] = above[c-1];
				assign nb.mid[0]   = mid[c-1];
				assign nb.below[0] = below[c-1];
			end else begin : g_left_edge
				assign nb.above[0] = 1'b0;
				assign nb.mid[0]   = 1'b0;
				assign nb.below[0] = 1'b0;
			end

			assign nb.above[1] = above[c];
			assign nb.mid[1]   = mid[c];
			assign nb.below[1] = below[c];

			if (c + 1 < LANES) begin : g_right
				assign nb.above[2] = above[c+1];
				assign nb.mid[2]   = mid[c+1];
				assign nb.below[2] = below[c+1];
			end else begin : g_right_edge
				assign nb.above[2] = 1'b0;
				assign nb.mid[2]   = 1'b0;
				assign nb.below[2] = 1'b0;
			end

			lgr_cell u_cell (
				.nbhd  (nb),
				.alive (bit_alive)
			);

			assign res[c] = bit_alive;
		end else begin : g_unused
			assign res[c] = 1'b0;
		end
	end

endmodule

// ===== rtl/lgr_outq.sv =====
// Small result queue: takes up to two beats per cycle, releases one when out_ready is high.
module lgr_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  lgr_pkg::push_t      push,
	output logic                can_accept,
	output logic                out_valid,
	input  logic                out_ready,
	output lgr_pkg::out_beat_t  out_data
);

	lgr_pkg::out_beat_t                  entries_q [lgr_pkg::OUTQ_DEPTH];
	logic [lgr_pkg::OUTQ_PTR_W-1:0]      wr_ptr_q;
	logic [lgr_pkg::OUTQ_PTR_W-1:0]      rd_ptr_q;
	logic [lgr_pkg::OUTQ_CNT_W-1:0]      count_q;
	logic                                pop;
	logic [lgr_pkg::OUTQ_PTR_W-1:0]      wr_ptr_nxt;

	assign out_valid  = (count_q != '0);
	assign out_data   = entries_q[rd_ptr_q];
	assign pop        = out_valid && out_ready;
	// From the registered fill level only: room for two more beats whatever the output does this cycle
	assign can_accept = (count_q <= lgr_pkg::OUTQ_ACCEPT_MAX);
	assign wr_ptr_nxt = wr_ptr_q + lgr_pkg::OUTQ_PTR_W'(1);

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + lgr_pkg::OUTQ_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lgr_pkg::OUTQ_PTR_W'(1);
			end
			count_q <= count_q + lgr_pkg::OUTQ_CNT_W'(push.cnt)
				- lgr_pkg::OUTQ_CNT_W'(pop);
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != lgr_pkg::PUSH_NONE) begin
			entries_q[wr_ptr_q] <= push.beat0;
		end
		if (push.cnt == lgr_pkg::PUSH_TWO) begin
			entries_q[wr_ptr_nxt] <= push.beat1;
		end
	end

endmodule

// ===== rtl/life_generation_row_engine_top.sv =====
// Top level of the Game of Life (B3/S23) row engine.
// One grid row enters per beat, top row first, the bottom row marked by last_row; the
// engine takes a row every clock cycle while the result queue has room. Each row's next
// generation is pushed into the result queue when the row below it enters, and the bottom
// row also releases its own result right behind it, so a grid of R rows yields R result beats.
// All cells of a row are worked out at once by one rule lane per column, so no loop limits
// the rate; a four-entry result queue decouples the output, and input stalls only while three
// or more results wait. Columns at GRID_WIDTH and above (or beyond 32) are treated as dead and come out zero.
module life_generation_row_engine_top #(
	parameter int unsigned GRID_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lgr_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output lgr_pkg::out_beat_t out_data
);

	localparam int unsigned LANES = (GRID_WIDTH > lgr_pkg::ROW_BITS) ?
		lgr_pkg::ROW_BITS : GRID_WIDTH;
	localparam logic [lgr_pkg::ROW_BITS-1:0] COL_MASK = lgr_pkg::lane_mask(LANES);

	logic [lgr_pkg::ROW_BITS-1:0] upper_q;
	logic [lgr_pkg::ROW_BITS-1:0] middle_q;
	logic                         have_row_q;
	logic [lgr_pkg::ROW_BITS-1:0] row;
	logic                         accept;
	logic [lgr_pkg::ROW_BITS-1:0] a_above;
	logic [lgr_pkg::ROW_BITS-1:0] a_mid;
	logic [lgr_pkg::ROW_BITS-1:0] a_below;
	logic [lgr_pkg::ROW_BITS-1:0] a_res;
	logic [lgr_pkg::ROW_BITS-1:0] b_res;
	lgr_pkg::push_t               push;

	assign row    = in_data.row_cells & COL_MASK;
	assign accept = in_valid && in_ready;

	// Result for the held middle row, or for a lone single-row grid
	assign a_above = have_row_q ? upper_q : '0;
	assign a_mid   = have_row_q ? middle_q : row;
	assign a_below = have_row_q ? row : '0;

	lgr_row #(.LANES(LANES)) u_row_a (
		.above (a_above),
		.mid   (a_mid),
		.below (a_below),
		.res   (a_res)
	);

	// Flush result for the bottom row itself
	lgr_row #(.LANES(LANES)) u_row_b (
		.above (middle_q),
		.mid   (row),
		.below ('0),
		.res   (b_res)
	);

	// Results pushed for this beat
	always_comb begin
		push.beat0.next_row = a_res;
		push.beat0.last_out = !have_row_q;
		push.beat1.next_row = b_res;
		push.beat1.last_out = 1'b1;
		push.cnt            = lgr_pkg::PUSH_NONE;
		if (accept) begin
			if (have_row_q && in_data.last_row) begin
				push.cnt = lgr_pkg::PUSH_TWO;
			end else if (have_row_q || in_data.last_row) begin
				push.cnt = lgr_pkg::PUSH_ONE;
			end
		end
	end

	// Row window: rows above and at the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q    <= '0;
			middle_q   <= '0;
			have_row_q <= 1'b0;
		end else if (accept) begin
			if (in_data.last_row) begin
				upper_q    <= '0;
				middle_q   <= '0;
				have_row_q <= 1'b0;
			end else begin
				upper_q    <= have_row_q ? middle_q : '0;
				middle_q   <= row;
				have_row_q <= 1'b1;
			end
		end
	end

	lgr_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.can_accept (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== rtl/lgr_checker.sv =====
// Port-level checks for the row engine, bound to the top level.
module lgr_checker #(
	parameter int unsigned GRID_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  lgr_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  lgr_pkg::out_beat_t out_data
);

	localparam int unsigned LANES = (GRID_WIDTH > lgr_pkg::ROW_BITS) ?
		lgr_pkg::ROW_BITS : GRID_WIDTH;
	localparam logic [lgr_pkg::ROW_BITS-1:0] COL_MASK = lgr_pkg::lane_mask(LANES);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	// A bottom row always yields at least one result right after it
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_row |=> out_valid)
		else $error("bottom row produced no result");

	// Input only stalls behind pending results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// Columns outside the grid are always dead
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.next_row & ~COL_MASK) == '0))
		else $error("live cell outside the grid");

endmodule

bind life_generation_row_engine_top lgr_checker #(.GRID_WIDTH(GRID_WIDTH)) u_lgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ===== bench/tb_life_generation_row_engine_top.sv =====
// Self-checking bench for the Game of Life row engine: directed grids, then random grids.
module tb_life_generation_row_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned ROW_BITS = lgr_pkg::ROW_BITS;
	localparam int unsigned GRID_W = 32;
	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;
	localparam int ROWS_PER_PHASE = 545;
	localparam int NUM_DIRECTED = 19;

	// One directed row; typed rows carry their results, the rest use the predictor
	typedef struct packed {
		lgr_pkg::in_beat_t  beat;
		logic               typed;
		logic [1:0]         n_typed;
		lgr_pkg::out_beat_t r0;
		lgr_pkg::out_beat_t r1;
	} dir_row_t;

	localparam lgr_pkg::out_beat_t NO_BEAT = '0;

	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		// single-row grids: neighbors only within the row
		'{'{32'h0000_0000, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 1'b1}, NO_BEAT},
		'{'{32'hFFFF_FFFF, 1'b1}, 1'b1, 2'd1, '{32'h7FFF_FFFE, 1'b1}, NO_BEAT},
		'{'{32'h0000_0007, 1'b1}, 1'b1, 2'd1, '{32'h0000_0002, 1'b1}, NO_BEAT},
		// vertical blinker turns horizontal
		'{'{32'h0000_0002, 1'b0}, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'h0000_0002, 1'b0}, 1'b1, 2'd1, '{32'h0000_0000, 1'b0}, NO_BEAT},
		'{'{32'h0000_0002, 1'b1}, 1'b1, 2'd2, '{32'h0000_0007, 1'b0},
			'{32'h0000_0000, 1'b1}},
		// two-row block is a still life
		'{'{32'h0000_0003, 1'b0}, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'h0000_0003, 1'b1}, 1'b1, 2'd2, '{32'h0000_0003, 1'b0},
			'{32'h0000_0003, 1'b1}},
		// edge columns
		'{'{32'h8000_0001, 1'b0}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'hC000_0003, 1'b0}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'h8000_0001, 1'b1}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		// full 3-row grid: only the corners survive
		'{'{32'hFFFF_FFFF, 1'b0}, 1'b1, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'hFFFF_FFFF, 1'b0}, 1'b1, 2'd1, '{32'h8000_0001, 1'b0}, NO_BEAT},
		'{'{32'hFFFF_FFFF, 1'b1}, 1'b1, 2'd2, '{32'h0000_0000, 1'b0},
			'{32'h8000_0001, 1'b1}},
		// checkerboard
		'{'{32'hAAAA_AAAA, 1'b0}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'h5555_5555, 1'b0}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'hAAAA_AAAA, 1'b0}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		'{'{32'h5555_5555, 1'b1}, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
		// lone cell on the top column dies
		'{'{32'h8000_0000, 1'b1}, 1'b1, 2'd1, '{32'h0000_0000, 1'b1}, NO_BEAT}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	lgr_pkg::in_beat_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	lgr_pkg::out_beat_t out_data;

	// Predictor state: the two held rows and how many rows of the grid are held
	logic [ROW_BITS-1:0] held_upper = '0;
	logic [ROW_BITS-1:0] held_middle = '0;
	logic [1:0]          rows_held = '0;

	lgr_pkg::out_beat_t expected_rows [$];

	int send_gap_pct = 30;
	int recv_gap_pct = 59;
	int errors = 0;
	int cycles = 0;
	int rows_sent = 0;
	int grids_sent = 0;
	int results_checked = 0;

	life_generation_row_engine_top #(
		.GRID_WIDTH(GRID_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Columns that exist in the grid
	function automatic logic [ROW_BITS-1:0] grid_mask();
		int unsigned w;
		logic [63:0] m;
		w = (GRID_W > ROW_BITS) ? ROW_BITS : GRID_W;
		m = (64'd1 << w) - 64'd1;
		return m[ROW_BITS-1:0];
	endfunction

	function automatic int cell_at(logic [ROW_BITS-1:0] row, int col);
		if (col < 0 || col >= int'(ROW_BITS))
			return 0;
		return int'(row[col]);
	endfunction

	// B3/S23 on the middle row, given its neighbors above and below
	function automatic logic [ROW_BITS-1:0] evolve_row(logic [ROW_BITS-1:0] above,
			logic [ROW_BITS-1:0] mid, logic [ROW_BITS-1:0] below);
		logic [ROW_BITS-1:0] mask;
		logic [ROW_BITS-1:0] nxt;
		int n;
		mask = grid_mask();
		above &= mask;
		mid &= mask;
		below &= mask;
		nxt = '0;
		for (int col = 0; col < int'(ROW_BITS); col++) begin
			n = 0;
			for (int d = -1; d <= 1; d++) begin
				n += cell_at(above, col + d) + cell_at(below, col + d);
				if (d != 0)
					n += cell_at(mid, col + d);
			end
			nxt[col] = (n == 3) || (n == 2 && cell_at(mid, col) == 1);
		end
		return nxt & mask;
	endfunction

	// Advance the held rows by one accepted row and produce its results
	task automatic predict_row(input lgr_pkg::in_beat_t b, output int n,
			output lgr_pkg::out_beat_t r0, output lgr_pkg::out_beat_t r1);
		logic [ROW_BITS-1:0] row;
		row = b.row_cells & grid_mask();
		n = 0;
		r0 = '0;
		r1 = '0;
		if (rows_held == 2'd0) begin
			if (b.last_row) begin
				r0 = '{evolve_row('0, row, '0), 1'b1};
				n = 1;
				held_upper = '0;
				held_middle = '0;
			end else begin
				held_upper = '0;
				held_middle = row;
				rows_held = 2'd1;
			end
		end else begin
			r0 = '{evolve_row(held_upper, held_middle, row), 1'b0};
			n = 1;
			held_upper = held_middle;
			held_middle = row;
			if (b.last_row) begin
				r1 = '{evolve_row(held_upper, held_middle, '0), 1'b1};
				n = 2;
				held_upper = '0;
				held_middle = '0;
				rows_held = 2'd0;
			end else begin
				rows_held = 2'd2;
			end
		end
	endtask

	// Drive one row beat from a falling edge; returns at the falling edge after acceptance
	task automatic send_row(input lgr_pkg::in_beat_t b, input logic typed,
			input logic [1:0] n_typed, input lgr_pkg::out_beat_t t0,
			input lgr_pkg::out_beat_t t1);
		int n;
		lgr_pkg::out_beat_t p0;
		lgr_pkg::out_beat_t p1;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_row(b, n, p0, p1);
		if (typed) begin
			n = int'(n_typed);
			p0 = t0;
			p1 = t1;
		end
		if (n > 0)
			expected_rows.push_back(p0);
		if (n > 1)
			expected_rows.push_back(p1);
		rows_sent++;
		if (b.last_row)
			grids_sent++;
		@(negedge clk);
	endtask

	// Random row content of varying density
	function automatic logic [ROW_BITS-1:0] random_row();
		case ($urandom_range(7))
			0: return $urandom & $urandom;
			1: return $urandom | $urandom;
			2: return ROW_BITS'($urandom_range(7)) << $urandom_range(ROW_BITS - 1);
			3: return $urandom_range(1) ? '1 : '0;
			default: return $urandom;
		endcase
	endfunction

	// Mostly short grids, a few tall ones
	function automatic int pick_height();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 6);
		if (r < 95)
			return $urandom_range(7, 20);
		return $urandom_range(21, 40);
	endfunction

	task automatic send_grid(input int height);
		lgr_pkg::in_beat_t b;
		for (int r = 0; r < height; r++) begin
			b.row_cells = random_row();
			b.last_row = (r == height - 1);
			send_row(b, 1'b0, 2'd0, NO_BEAT, NO_BEAT);
		end
	endtask

	// Hold off the sender until every outstanding result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver backpressure
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
	end

	// Result checker
	always @(posedge clk) begin
		lgr_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rows.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, got next_row %h last_out %b",
					$time, out_data.next_row, out_data.last_out);
			end else begin
				want = expected_rows.pop_front();
				results_checked++;
				if (out_data.next_row !== want.next_row) begin
					errors++;
					$display("%0t: next_row mismatch, expected %h, got %h",
						$time, want.next_row, out_data.next_row);
				end
				if (out_data.last_out !== want.last_out) begin
					errors++;
					$display("%0t: last_out mismatch, expected %b, got %b",
						$time, want.last_out, out_data.last_out);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_rows.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int phase_start;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed grids
		foreach (DIRECTED[i])
			send_row(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].n_typed,
				DIRECTED[i].r0, DIRECTED[i].r1);
		drain();

		// Random grids under three idle patterns, draining between phases
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 30;
					recv_gap_pct = 59;
				end
				1: begin
					send_gap_pct = 59;
					recv_gap_pct = 30;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			phase_start = rows_sent;
			while (rows_sent - phase_start < ROWS_PER_PHASE)
				send_grid(pick_height());
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d grids, %0d row beats in, %0d result beats checked, %0d cycles.",
			grids_sent, rows_sent, results_checked, cycles);
		$display("Idle mixes: sender-heavy, receiver-heavy and back-to-back; %0d mismatches.",
			errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
